// ===== src/vvpu_pkg.sv =====
// ----------------------------------------------------------------------------
// Velocity Verlet particle update package
// Shared widths, codes, lane interface types and saturation helpers.
// ----------------------------------------------------------------------------
package vvpu_pkg;

  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned W40 = 40;
  localparam int unsigned DT_W = 24;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned CFG_W = 48;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned SHIFT_W = 8;
  localparam int unsigned SPEED_W = 64;
  localparam int unsigned DIV_STEPS = 44;
  localparam int unsigned CNT_W = 6;

  localparam logic OP_FIRST = 1'b0;
  localparam logic OP_SECOND = 1'b1;

  localparam logic [IDX_W-1:0] REG_TIME_STEP = 3'd0;
  localparam logic [IDX_W-1:0] REG_BOX_X = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOX_Y = 3'd2;
  localparam logic [IDX_W-1:0] REG_BOX_Z = 3'd3;
  localparam logic [IDX_W-1:0] REG_DRIFT = 3'd4;
  localparam logic [IDX_W-1:0] REG_POS_SCALE = 3'd5;
  localparam logic [IDX_W-1:0] REG_VEL_SCALE = 3'd6;

  localparam logic [DT_W-1:0] TIME_STEP_RESET = 24'd65536;
  localparam logic [W40-1:0] BOX_RESET = 40'd655360;
  localparam logic [CFG_W-1:0] SCALE_RESET = 48'h4000_4000_4000;

  localparam logic signed [W40-1:0] MAX40 = {1'b0, {(W40-1){1'b1}}};
  localparam logic signed [W40-1:0] MIN40 = {1'b1, {(W40-1){1'b0}}};

  typedef struct packed {
    logic [DT_W-1:0]    time_step;
    logic [W40-1:0]     box_length;
    logic [SCALE_W-1:0] drift_scale;
    logic [SCALE_W-1:0] pos_scale;
    logic [SCALE_W-1:0] vel_scale;
  } lane_cfg_t;

  typedef struct packed {
    logic signed [W40-1:0]     new_pos;
    logic signed [W40-1:0]     new_vel;
    logic signed [SHIFT_W-1:0] image_shift;
    logic [SPEED_W-1:0]        vel_sq;
  } lane_result_t;

  function automatic logic signed [W40-1:0] sat40(input logic signed [46:0] x);
    logic signed [W40-1:0] y;
    if (x > 47'(MAX40)) begin
      y = MAX40;
    end else if (x < 47'(MIN40)) begin
      y = MIN40;
    end else begin
      y = x[W40-1:0];
    end
    return y;
  endfunction

  function automatic logic [SPEED_W-1:0] sat_add64(input logic [SPEED_W-1:0] a,
                                                   input logic [SPEED_W-1:0] b);
    logic [SPEED_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SPEED_W] ? {SPEED_W{1'b1}} : s[SPEED_W-1:0];
  endfunction

endpackage

// ===== src/vvpu_lane.sv =====
// ----------------------------------------------------------------------------
// Velocity Verlet axis lane
// Kick, drift, rescale and floor wrap of one axis, with a bit-serial divider.
// ----------------------------------------------------------------------------
module vvpu_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          opcode,
  input  logic signed [vvpu_pkg::W40-1:0] pos,
  input  logic signed [vvpu_pkg::W40-1:0] vel,
  input  logic signed [vvpu_pkg::W40-1:0] force_in,
  input  vvpu_pkg::lane_cfg_t           cfg,
  output logic                          done,
  output vvpu_pkg::lane_result_t        result
);

  typedef enum logic [3:0] {
    L_IDLE, L_KICK, L_VEL, L_MUL, L_DRIFT, L_POSN, L_SCALE, L_PREP, L_DIV, L_FIN, L_DONE
  } lane_state_t;

  lane_state_t state;
  logic op;
  logic signed [39:0] p_q, v_q, f_q;
  logic signed [64:0] kprod;
  logic signed [39:0] v1;
  logic signed [64:0] tprod;
  logic signed [56:0] vprod;
  logic signed [56:0] dprod;
  logic signed [43:0] x;
  logic signed [60:0] sprod;
  logic signed [44:0] xs;
  logic [39:0] rem;
  logic [43:0] quo;
  logic [vvpu_pkg::CNT_W-1:0] cnt;

  logic signed [40:0] kick_sum;
  logic [39:0] vmag;
  logic signed [44:0] xs_next;
  logic [41:0] trial;
  logic [39:0] r_neg;
  logic qbig;

  always_comb begin
    kick_sum = {v_q[39], v_q} + {kprod[64], kprod[64:25]};
    vmag = v1[39] ? 40'(-v1) : 40'(v1);
    xs_next = sprod[58:14];
    trial = {1'b0, rem, quo[43]} - {2'b00, cfg.box_length};
    r_neg = cfg.box_length - rem - 40'd1;
    qbig = |quo[43:7];
  end

  assign done = (state == L_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            op <= opcode;
            p_q <= pos;
            v_q <= vel;
            f_q <= force_in;
            state <= L_KICK;
          end
        end
        L_KICK: begin
          kprod <= f_q * $signed({1'b0, cfg.time_step});
          state <= L_VEL;
        end
        L_VEL: begin
          v1 <= vvpu_pkg::sat40(47'(kick_sum));
          state <= L_MUL;
        end
        L_MUL: begin
          tprod <= v1 * $signed({1'b0, cfg.time_step});
          vprod <= v1 * $signed({1'b0, cfg.vel_scale});
          result.vel_sq <= (|vmag[39:32]) ? {vvpu_pkg::SPEED_W{1'b1}}
                                          : vmag[31:0] * vmag[31:0];
          state <= L_DRIFT;
        end
        L_DRIFT: begin
          dprod <= $signed(tprod[63:24]) * $signed({1'b0, cfg.drift_scale});
          state <= L_POSN;
        end
        L_POSN: begin
          x <= 44'(p_q) + 44'($signed(dprod[56:14]));
          state <= L_SCALE;
        end
        L_SCALE: begin
          sprod <= x * $signed({1'b0, cfg.pos_scale});
          state <= L_PREP;
        end
        L_PREP: begin
          xs <= xs_next;
          rem <= '0;
          quo <= xs_next[44] ? ~xs_next[43:0] : xs_next[43:0];
          cnt <= vvpu_pkg::CNT_W'(vvpu_pkg::DIV_STEPS);
          state <= (op == vvpu_pkg::OP_SECOND) ? L_FIN : L_DIV;
        end
        L_DIV: begin
          if (!trial[41]) begin
            rem <= trial[39:0];
            quo <= {quo[42:0], 1'b1};
          end else begin
            rem <= {rem[38:0], quo[43]};
            quo <= {quo[42:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == 1) begin
            state <= L_FIN;
          end
        end
        L_FIN: begin
          if (op == vvpu_pkg::OP_SECOND) begin
            result.new_pos <= p_q;
            result.new_vel <= v1;
            result.image_shift <= '0;
          end else begin
            result.new_vel <= vvpu_pkg::sat40(47'($signed(vprod[56:14])));
            if (cfg.box_length == '0) begin
              result.new_pos <= vvpu_pkg::sat40(47'(xs));
              result.image_shift <= '0;
            end else if (xs[44]) begin
              result.new_pos <= r_neg[39] ? vvpu_pkg::MAX40 : $signed(r_neg);
              result.image_shift <= qbig ? -8'sd128 : $signed(~quo[7:0]);
            end else begin
              result.new_pos <= rem[39] ? vvpu_pkg::MAX40 : $signed(rem);
              result.image_shift <= qbig ? 8'sd127 : $signed({1'b0, quo[6:0]});
            end
          end
          state <= L_DONE;
        end
        L_DONE: begin
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/vvpu_merge.sv =====
// ----------------------------------------------------------------------------
// Velocity Verlet speed merge
// Sums the three lane squares with saturation over two register steps.
// ----------------------------------------------------------------------------
module vvpu_merge (
  input  logic                            clk,
  input  logic                            load,
  input  logic [vvpu_pkg::SPEED_W-1:0]    sq_x,
  input  logic [vvpu_pkg::SPEED_W-1:0]    sq_y,
  input  logic [vvpu_pkg::SPEED_W-1:0]    sq_z,
  output logic [vvpu_pkg::SPEED_W-1:0]    speed
);

  logic [vvpu_pkg::SPEED_W-1:0] partial;
  logic [vvpu_pkg::SPEED_W-1:0] sq_z_q;

  always_ff @(posedge clk) begin
    if (load) begin
      partial <= vvpu_pkg::sat_add64(sq_x, sq_y);
      sq_z_q <= sq_z;
    end
    speed <= vvpu_pkg::sat_add64(partial, sq_z_q);
  end

endmodule

// ===== src/velocity_verlet_particle_update.sv =====
// ----------------------------------------------------------------------------
// Velocity Verlet particle update
// Three axis lanes and a merge stage behind a valid/stall stream interface.
// ----------------------------------------------------------------------------
// One particle is in flight at a time. A first-half transaction runs the
// 44-step bit-serial floor divider in each axis lane; a second-half
// transaction skips the divider. The input is stalled from acceptance until
// the result is loaded into the output register, which happens as soon as
// that register is free. The next transaction is accepted while an earlier
// result still waits to be taken. Configuration writes must only happen
// while the block is idle.
module velocity_verlet_particle_update (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [vvpu_pkg::IDX_W-1:0]           cfg_index,
  input  logic [vvpu_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic                                 sweep_start,
  input  logic signed [39:0]                   pos_x,
  input  logic signed [39:0]                   pos_y,
  input  logic signed [39:0]                   pos_z,
  input  logic signed [39:0]                   vel_x,
  input  logic signed [39:0]                   vel_y,
  input  logic signed [39:0]                   vel_z,
  input  logic signed [39:0]                   force_x,
  input  logic signed [39:0]                   force_y,
  input  logic signed [39:0]                   force_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [39:0]                   new_pos_x,
  output logic signed [39:0]                   new_pos_y,
  output logic signed [39:0]                   new_pos_z,
  output logic signed [39:0]                   new_vel_x,
  output logic signed [39:0]                   new_vel_y,
  output logic signed [39:0]                   new_vel_z,
  output logic signed [7:0]                    image_shift_x,
  output logic signed [7:0]                    image_shift_y,
  output logic signed [7:0]                    image_shift_z,
  output logic [63:0]                          speed_sq,
  output logic [63:0]                          max_speed_sq
);

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_SUM, T_PUSH} top_state_t;

  top_state_t state;
  logic [vvpu_pkg::DT_W-1:0] time_step;
  logic [vvpu_pkg::W40-1:0] box_len [vvpu_pkg::NUM_LANES];
  logic [vvpu_pkg::CFG_W-1:0] drift_scales, position_scales, velocity_scales;
  logic [63:0] running_max;
  logic op_q, start_q;

  logic in_accept, out_free;
  logic signed [39:0] pos_a [vvpu_pkg::NUM_LANES];
  logic signed [39:0] vel_a [vvpu_pkg::NUM_LANES];
  logic signed [39:0] force_a [vvpu_pkg::NUM_LANES];
  vvpu_pkg::lane_cfg_t lane_cfg [vvpu_pkg::NUM_LANES];
  vvpu_pkg::lane_result_t lane_res [vvpu_pkg::NUM_LANES];
  logic [vvpu_pkg::NUM_LANES-1:0] lane_done;
  logic [63:0] speed;
  logic [63:0] speed_out, max_next;

  assign in_stall = (state != T_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign pos_a[0] = pos_x;
  assign pos_a[1] = pos_y;
  assign pos_a[2] = pos_z;
  assign vel_a[0] = vel_x;
  assign vel_a[1] = vel_y;
  assign vel_a[2] = vel_z;
  assign force_a[0] = force_x;
  assign force_a[1] = force_y;
  assign force_a[2] = force_z;

  for (genvar i = 0; i < vvpu_pkg::NUM_LANES; i++) begin : g_lane
    always_comb begin
      lane_cfg[i].time_step = time_step;
      lane_cfg[i].box_length = box_len[i];
      lane_cfg[i].drift_scale = drift_scales[16*i +: 16];
      lane_cfg[i].pos_scale = position_scales[16*i +: 16];
      lane_cfg[i].vel_scale = velocity_scales[16*i +: 16];
    end

    vvpu_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .start    (in_accept),
      .opcode   (opcode),
      .pos      (pos_a[i]),
      .vel      (vel_a[i]),
      .force_in (force_a[i]),
      .cfg      (lane_cfg[i]),
      .done     (lane_done[i]),
      .result   (lane_res[i])
    );
  end

  vvpu_merge u_merge (
    .clk   (clk),
    .load  (state == T_RUN && lane_done[0]),
    .sq_x  (lane_res[0].vel_sq),
    .sq_y  (lane_res[1].vel_sq),
    .sq_z  (lane_res[2].vel_sq),
    .speed (speed)
  );

  always_comb begin
    speed_out = (op_q == vvpu_pkg::OP_SECOND) ? speed : '0;
    if (op_q == vvpu_pkg::OP_SECOND && (start_q || speed > running_max)) begin
      max_next = speed;
    end else begin
      max_next = running_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      out_valid <= 1'b0;
      running_max <= '0;
      time_step <= vvpu_pkg::TIME_STEP_RESET;
      box_len[0] <= vvpu_pkg::BOX_RESET;
      box_len[1] <= vvpu_pkg::BOX_RESET;
      box_len[2] <= vvpu_pkg::BOX_RESET;
      drift_scales <= vvpu_pkg::SCALE_RESET;
      position_scales <= vvpu_pkg::SCALE_RESET;
      velocity_scales <= vvpu_pkg::SCALE_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          vvpu_pkg::REG_TIME_STEP: time_step <= cfg_data[vvpu_pkg::DT_W-1:0];
          vvpu_pkg::REG_BOX_X:     box_len[0] <= cfg_data[vvpu_pkg::W40-1:0];
          vvpu_pkg::REG_BOX_Y:     box_len[1] <= cfg_data[vvpu_pkg::W40-1:0];
          vvpu_pkg::REG_BOX_Z:     box_len[2] <= cfg_data[vvpu_pkg::W40-1:0];
          vvpu_pkg::REG_DRIFT:     drift_scales <= cfg_data;
          vvpu_pkg::REG_POS_SCALE: position_scales <= cfg_data;
          vvpu_pkg::REG_VEL_SCALE: velocity_scales <= cfg_data;
          default: begin
          end
        endcase
      end

      if (out_valid && !out_stall && state != T_PUSH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        T_IDLE: begin
          if (in_accept) begin
            op_q <= opcode;
            start_q <= sweep_start;
            state <= T_RUN;
          end
        end
        T_RUN: begin
          if (lane_done[0]) begin
            state <= T_SUM;
          end
        end
        T_SUM: begin
          state <= T_PUSH;
        end
        T_PUSH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            new_pos_x <= lane_res[0].new_pos;
            new_pos_y <= lane_res[1].new_pos;
            new_pos_z <= lane_res[2].new_pos;
            new_vel_x <= lane_res[0].new_vel;
            new_vel_y <= lane_res[1].new_vel;
            new_vel_z <= lane_res[2].new_vel;
            image_shift_x <= lane_res[0].image_shift;
            image_shift_y <= lane_res[1].image_shift;
            image_shift_z <= lane_res[2].image_shift;
            speed_sq <= speed_out;
            max_speed_sq <= max_next;
            running_max <= max_next;
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] == lane_done[1] && lane_done[1] == lane_done[2])
    else $error("axis lanes finished in different cycles");

  a_max_covers_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> max_speed_sq >= speed_sq)
    else $error("running maximum below reported speed");

  a_no_shift_with_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && speed_sq != '0) |->
      (image_shift_x == '0 && image_shift_y == '0 && image_shift_z == '0))
    else $error("image shift reported in a second-half transaction");

  a_done_only_running: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> state == T_RUN)
    else $error("lane finished while no transaction was in flight");
`endif

endmodule
